// File: sv/dlfs_pkg.sv
package dlfs_pkg;

    localparam int MASK_W    = 64;
    localparam int NUM_MASK  = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MASK_Q0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_Q1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_Q2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_Q3 = 2'd3;

    localparam logic KIND_RAW = 1'b0;
    localparam logic KIND_EVT = 1'b1;

    localparam logic [1:0] WIN_FULL = 2'd2;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic load_raw;
        logic load_evt;
        logic raw_last;
        logic line_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic win_full;
        logic evt_hit;
        logic line_empty;
        logic line_will_full;
        logic rd_at_end;
        logic out_free;
    } t_dp_sts;

endpackage

// File: sv/debug_log_frame_splitter.sv
// Channel  | Dir | Handshake                    | Beat contents
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: rx_byte
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: value_byte, event_data; tuser: item_kind;
//          |     |                              | tlast: run_last
// cfg      | in  | i_cfg_we                     | i_cfg_idx: mask quarter, i_cfg_data: 64 bits
//
// A byte that causes no result leaves the block idle; the next byte is taken in the following cycle.
// A line flush sends its bytes one beat per cycle while the output is free, out of the
// single read port of the line memory; an event goes out alone or after flushing a pending line.
// Input is not taken during a flush or an event.
// Reset is synchronous, active low; no clearing pass is needed.
// In idle, a held result does not block the next input byte; it does stall a flush or event.
module debug_log_frame_splitter #(
    parameter int LINE_BYTES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dlfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dlfs_pkg::MASK_W-1:0]      i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [7:0] rx_byte
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [15:0]                      m_axis_tdata,   // [7:0] value_byte, [15:8] event_data
    output logic                             m_axis_tuser,   // [0] item_kind
    output logic                             m_axis_tlast
);
    import dlfs_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    dlfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dlfs_datapath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_rx_byte   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (m_axis_tuser),
        .o_out_value (m_axis_tdata[7:0]),
        .o_out_data  (m_axis_tdata[15:8]),
        .o_out_last  (m_axis_tlast)
    );

endmodule

// File: sv/dlfs_datapath.sv
module dlfs_datapath #(
    parameter int LINE_BYTES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dlfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dlfs_pkg::MASK_W-1:0]      i_cfg_data,
    input  logic [7:0]                       i_rx_byte,
    input  dlfs_pkg::t_dp_cmd                i_cmd,
    output dlfs_pkg::t_dp_sts                o_sts,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_out_kind,
    output logic [7:0]                       o_out_value,
    output logic [7:0]                       o_out_data,
    output logic                             o_out_last
);
    import dlfs_pkg::*;

    localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int LW = $clog2(LINE_BYTES + 1);

    logic [MASK_W-1:0] r_mask [NUM_MASK];
    logic [7:0]        r_win0;
    logic [7:0]        r_win1;
    logic [1:0]        r_win_fill;
    logic [LW-1:0]     r_line_fill;
    logic [AW-1:0]     r_rd_ptr;
    logic [7:0]        r_rd_data;
    logic [7:0]        r_evt_cmd;
    logic [7:0]        r_evt_data;
    logic [7:0]        r_line_mem [LINE_BYTES];

    logic r_out_valid;
    logic r_out_kind;
    logic [7:0] r_out_value;
    logic [7:0] r_out_data;
    logic r_out_last;

    logic w_mask_bit;
    logic w_evt_hit;
    logic w_shift;

    assign w_mask_bit = r_mask[r_win0[7:6]][r_win0[5:0]];
    assign w_evt_hit  = (r_win_fill == WIN_FULL) && (r_win0 == i_rx_byte) && w_mask_bit;
    assign w_shift    = i_cmd.accept && (r_win_fill == WIN_FULL) && !w_evt_hit;

    always_comb begin
        o_sts.win_full       = (r_win_fill == WIN_FULL);
        o_sts.evt_hit        = w_evt_hit;
        o_sts.line_empty     = (r_line_fill == '0);
        o_sts.line_will_full = ((r_line_fill + LW'(1)) == LW'(LINE_BYTES));
        o_sts.rd_at_end      = ((LW'(r_rd_ptr) + LW'(1)) == r_line_fill);
        o_sts.out_free       = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_MASK; i++) begin
                r_mask[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MASK_Q0: r_mask[0] <= i_cfg_data;
                REG_MASK_Q1: r_mask[1] <= i_cfg_data;
                REG_MASK_Q2: r_mask[2] <= i_cfg_data;
                REG_MASK_Q3: r_mask[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_fill <= '0;
        end else if (i_cmd.accept) begin
            if (r_win_fill != WIN_FULL) begin
                r_win_fill <= r_win_fill + 2'd1;
            end else if (w_evt_hit) begin
                r_win_fill <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (r_win_fill == 2'd0) begin
                r_win0 <= i_rx_byte;
            end else if (r_win_fill == 2'd1) begin
                r_win1 <= i_rx_byte;
            end else if (w_evt_hit) begin
                r_evt_cmd  <= r_win0;
                r_evt_data <= r_win1;
            end else begin
                r_win0 <= r_win1;
                r_win1 <= i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_fill <= '0;
            r_rd_ptr    <= '0;
        end else begin
            if (i_cmd.line_clr) begin
                r_line_fill <= '0;
            end else if (w_shift) begin
                r_line_fill <= r_line_fill + LW'(1);
            end
            if (i_cmd.line_clr) begin
                r_rd_ptr <= '0;
            end else if (i_cmd.rd_issue) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_line_mem[r_line_fill[AW-1:0]] <= r_win0;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_line_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_raw || i_cmd.load_evt) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_raw) begin
            r_out_kind  <= KIND_RAW;
            r_out_value <= r_rd_data;
            r_out_data  <= 8'd0;
            r_out_last  <= i_cmd.raw_last;
        end else if (i_cmd.load_evt) begin
            r_out_kind  <= KIND_EVT;
            r_out_value <= r_evt_cmd;
            r_out_data  <= r_evt_data;
            r_out_last  <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_value = r_out_value;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_fill <= LW'(LINE_BYTES))
        else $error("line fill beyond line length");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_raw || i_cmd.load_evt) |-> (!r_out_valid || i_out_ready))
        else $error("output overwritten while held");

    a_clr_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.line_clr |=> (r_line_fill == '0) && (r_rd_ptr == '0))
        else $error("line not emptied after flush");

endmodule

// File: sv/dlfs_ctrl.sv
module dlfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dlfs_pkg::t_dp_sts i_sts,
    output dlfs_pkg::t_dp_cmd o_cmd
);
    import dlfs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FLUSH,
        S_EVENT
    } t_state;

    t_state r_state, n_state;
    logic   r_rd_valid, n_rd_valid;
    logic   r_rd_last, n_rd_last;
    logic   r_rd_done, n_rd_done;
    logic   r_evt_pend, n_evt_pend;

    always_comb begin
        n_state    = r_state;
        n_rd_valid = r_rd_valid;
        n_rd_last  = r_rd_last;
        n_rd_done  = r_rd_done;
        n_evt_pend = r_evt_pend;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                n_rd_valid   = 1'b0;
                n_rd_last    = 1'b0;
                n_rd_done    = 1'b0;
                if (i_in_valid && i_sts.win_full) begin
                    if (i_sts.evt_hit) begin
                        n_evt_pend = 1'b1;
                        n_state    = i_sts.line_empty ? S_EVENT : S_FLUSH;
                    end else if (i_sts.line_will_full) begin
                        n_evt_pend = 1'b0;
                        n_state    = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                o_cmd.load_raw = r_rd_valid && i_sts.out_free;
                o_cmd.raw_last = r_rd_last && !r_evt_pend;
                o_cmd.rd_issue = !r_rd_done && (!r_rd_valid || o_cmd.load_raw);
                if (o_cmd.rd_issue) begin
                    n_rd_valid = 1'b1;
                    n_rd_last  = i_sts.rd_at_end;
                    n_rd_done  = i_sts.rd_at_end;
                end else if (o_cmd.load_raw) begin
                    n_rd_valid = 1'b0;
                end
                if (o_cmd.load_raw && r_rd_last) begin
                    o_cmd.line_clr = 1'b1;
                    n_state        = r_evt_pend ? S_EVENT : S_IDLE;
                end
            end
            S_EVENT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_evt = 1'b1;
                    n_evt_pend     = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_valid <= 1'b0;
            r_rd_last  <= 1'b0;
            r_rd_done  <= 1'b0;
            r_evt_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= n_rd_valid;
            r_rd_last  <= n_rd_last;
            r_rd_done  <= n_rd_done;
            r_evt_pend <= n_evt_pend;
        end
    end

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.accept, o_cmd.load_raw, o_cmd.load_evt}))
        else $error("conflicting datapath commands");

    a_rd_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_state == S_FLUSH))
        else $error("read data pending outside flush");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_valid && r_rd_last) |-> r_rd_done)
        else $error("read issued past end of line");

endmodule

// File: test/debug_log_frame_splitter_tb.sv
`timescale 1ns / 100ps

module debug_log_frame_splitter_tb;

    import dlfs_pkg::*;

    localparam int LINE_BYTES = 32;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic [7:0] data;
        logic       last;
    } t_beat;

    class splitter_checker;
        logic [MASK_W-1:0] mask [NUM_MASK];
        logic [7:0]        win [3];
        int                win_fill;
        logic [7:0]        line [LINE_BYTES];
        int                line_fill;
        t_beat             expected_beats [$];
        int                errors;

        function new();
            foreach (mask[i]) mask[i] = '0;
            win_fill  = 0;
            line_fill = 0;
            errors    = 0;
        endfunction

        function void set_mask(int idx, logic [MASK_W-1:0] v);
            mask[idx] = v;
        endfunction

        function bit cmd_ok(logic [7:0] c);
            return mask[c[7:6]][c[5:0]];
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void push_beat(logic kind, logic [7:0] value, logic [7:0] data);
            t_beat b;
            b.kind  = kind;
            b.value = value;
            b.data  = data;
            b.last  = 1'b0;
            expected_beats.push_back(b);
        endfunction

        function void flush_line();
            for (int i = 0; i < line_fill; i++) push_beat(KIND_RAW, line[i], 8'h00);
            line_fill = 0;
        endfunction

        // predict the beats caused by one accepted byte
        function void take_byte(logic [7:0] b);
            int         n0;
            logic [7:0] oldest;
            t_beat      tail;
            n0 = expected_beats.size();
            win[win_fill] = b;
            win_fill++;
            if (win_fill == 3) begin
                if (win[0] == win[2] && cmd_ok(win[0])) begin
                    if (line_fill != 0) flush_line();
                    push_beat(KIND_EVT, win[0], win[1]);
                    win_fill = 0;
                end else begin
                    oldest = win[0];
                    win[0] = win[1];
                    win[1] = win[2];
                    win_fill = 2;
                    line[line_fill] = oldest;
                    line_fill++;
                    if (line_fill >= LINE_BYTES) flush_line();
                end
            end
            if (expected_beats.size() > n0) begin
                tail = expected_beats.pop_back();
                tail.last = 1'b1;
                expected_beats.push_back(tail);
            end
        endfunction

        task report_error(string what, int got, int want);
            $display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_beat(logic kind, logic [7:0] value, logic [7:0] data, logic last);
            t_beat want;
            if (expected_beats.size() == 0) begin
                report_error("beat with nothing expected, value", value, 0);
                return;
            end
            want = expected_beats.pop_front();
            if (kind !== want.kind)   report_error("item_kind", kind, want.kind);
            if (value !== want.value) report_error("value_byte", value, want.value);
            if (data !== want.data)   report_error("event_data", data, want.data);
            if (last !== want.last)   report_error("run_last", last, want.last);
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [MASK_W-1:0]    i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'h00;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;

    splitter_checker sb;
    bit              fast_tx = 1'b0;
    bit              fast_rx = 1'b0;
    int              sent = 0;

    debug_log_frame_splitter #(
        .LINE_BYTES(LINE_BYTES)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 49) == 0) fast_tx = !fast_tx;
        gap = fast_tx ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.take_byte(b);
        sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mask(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_mask(idx, v);
    endtask

    task automatic load_masks(input logic [MASK_W-1:0] v0, input logic [MASK_W-1:0] v1,
                              input logic [MASK_W-1:0] v2, input logic [MASK_W-1:0] v3);
        write_mask(REG_MASK_Q0, v0);
        write_mask(REG_MASK_Q1, v1);
        write_mask(REG_MASK_Q2, v2);
        write_mask(REG_MASK_Q3, v3);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_cmd();
        logic [7:0] ok [$];
        for (int i = 0; i < 256; i++) if (sb.cmd_ok(8'(i))) ok.push_back(8'(i));
        if (ok.size() == 0) return 8'($urandom_range(0, 255));
        return ok[$urandom_range(0, ok.size() - 1)];
    endfunction

    task automatic send_cmd(input logic [7:0] c, input logic [7:0] d, input logic [7:0] e);
        send_byte(c);
        send_byte(d);
        send_byte(e);
    endtask

    // mostly well-formed event triplets, the rest raw text and broken triplets
    task automatic run_random(input int count);
        int         target;
        int         sel;
        logic [7:0] c;
        target = sent + count;
        while (sent < target) begin
            sel = $urandom_range(0, 9);
            c = pick_cmd();
            if (sel < 6) begin
                send_cmd(c, 8'($urandom_range(0, 255)), c);
            end else if (sel < 9) begin
                repeat ($urandom_range(1, 40)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_cmd(c, 8'($urandom_range(0, 255)), c ^ 8'($urandom_range(1, 255)));
            end
        end
    endtask

    initial begin
        int stall;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 49) == 0) fast_rx = !fast_rx;
            stall = fast_rx ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            sb.check_beat(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
        end
    end

    initial begin
        #20_000_000;
        $display("debug_log_frame_splitter: mismatch");
        $finish;
    end

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all masks clear: partial window, equal ends rejected
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        wait_drained();

        load_masks(64'h1, 64'h1 | (64'h1 << 26), 64'h0, 64'h8000_0000_0000_0000);
        send_byte(8'hFF);                  // event after pending line
        send_cmd(8'h00, 8'h7E, 8'h00);     // event, empty line
        send_cmd(8'h5A, 8'h33, 8'h5A);
        send_cmd(8'h40, 8'hFF, 8'h40);
        send_cmd(8'h80, 8'h01, 8'h80);     // equal ends, command not enabled
        send_cmd(8'h12, 8'h34, 8'h12);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    load_masks('1, '1, '1, '1);
                end
                1: begin
                    load_masks({$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom}, {$urandom, $urandom});
                end
                2: begin
                    load_masks(64'h1 << $urandom_range(0, 63), 64'h1 << $urandom_range(0, 63),
                               64'h1 << $urandom_range(0, 63), 64'h1 << $urandom_range(0, 63));
                end
                default: begin
                    load_masks('0, '0, '0, '0);
                end
            endcase
            run_random(120);
            wait_drained();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("debug_log_frame_splitter: match");
        end else begin
            $display("debug_log_frame_splitter: mismatch");
        end
        $finish;
    end

endmodule

// File: debug_log_frame_splitter.f
sv/dlfs_pkg.sv
sv/dlfs_datapath.sv
sv/dlfs_ctrl.sv
sv/debug_log_frame_splitter.sv
test/debug_log_frame_splitter_tb.sv
